>>> rtl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    // Default widths of the position and time fields.
    localparam int POS_WIDTH_DEF  = 32;
    localparam int TIME_WIDTH_DEF = 40;

    // Fixed field widths.
    localparam int ID_W       = 16;
    localparam int PERIOD_W   = 40;
    localparam int SPEED_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PERIOD_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TRACKED_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_PERIOD = 1'b1;

    // Word kinds on the sample channel.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Reset values.
    localparam logic [ID_W-1:0]     TRACKED_ID_RESET    = '0;
    localparam logic [PERIOD_W-1:0] OUTPUT_PERIOD_RESET = 40'd10000;
    localparam int                  EMIT_RESET_US       = 1000000;

    // Scaling from metres per microsecond to metres per second.
    localparam int US_PER_S      = 1000000;
    localparam int US_SCALE_BITS = 20;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

endpackage

`default_nettype wire

>>> rtl/tss_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tss_sample_if #(
    parameter int POS_WIDTH  = tss_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = tss_pkg::TIME_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [tss_pkg::ID_W-1:0]     object_id;
    logic signed [POS_WIDTH-1:0]  pos_x;
    logic signed [POS_WIDTH-1:0]  pos_y;
    logic signed [POS_WIDTH-1:0]  pos_z;
    logic [TIME_WIDTH-1:0]        sample_time;

    modport source (
        output valid, kind, object_id, pos_x, pos_y, pos_z, sample_time,
        input  ready
    );

    modport sink (
        input  valid, kind, object_id, pos_x, pos_y, pos_z, sample_time,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/tss_speed_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tss_speed_if #(
    parameter int TIME_WIDTH = tss_pkg::TIME_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [tss_pkg::SPEED_W-1:0]   speed;
    logic [TIME_WIDTH-1:0]         speed_time;
    logic                          zero_interval;

    modport source (
        output valid, speed, speed_time, zero_interval,
        input  ready
    );

    modport sink (
        input  valid, speed, speed_time, zero_interval,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/tss_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Iterative speed engine: sum of squares on one multiplier, then a bit-serial
// square root, a constant scale and a bit-serial division, with the root and
// the division sharing one subtract-and-compare unit.
module tss_core #(
    parameter int POS_WIDTH  = tss_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = tss_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [POS_WIDTH-1:0]        dist_x,
    input  wire logic [POS_WIDTH-1:0]        dist_y,
    input  wire logic [POS_WIDTH-1:0]        dist_z,
    input  wire logic [TIME_WIDTH-1:0]       interval,
    output logic                             done,
    output logic [tss_pkg::SPEED_W-1:0]      speed
);

    localparam int RW     = POS_WIDTH + 1;
    localparam int SW     = 2 * RW;
    localparam int SQ_W   = 2 * POS_WIDTH;
    localparam int NUM_W  = RW + tss_pkg::US_SCALE_BITS;
    localparam int HI_W   = NUM_W - tss_pkg::SPEED_W;
    localparam int W_SUB  = (RW + 3 > TIME_WIDTH + 1) ? RW + 3 : TIME_WIDTH + 1;
    localparam int ITER_N = (RW > tss_pkg::SPEED_W) ? RW : tss_pkg::SPEED_W;
    localparam int CNT_W  = $clog2(ITER_N);

    typedef enum logic [6:0] {
        C_IDLE  = 7'b0000001,
        C_SQ    = 7'b0000010,
        C_ACC   = 7'b0000100,
        C_SQRT  = 7'b0001000,
        C_SCALE = 7'b0010000,
        C_CHK   = 7'b0100000,
        C_DIV   = 7'b1000000
    } core_state_t;

    core_state_t                  state_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         done_reg;
    logic [POS_WIDTH-1:0]         dx_reg;
    logic [POS_WIDTH-1:0]         dy_reg;
    logic [POS_WIDTH-1:0]         dz_reg;
    logic [TIME_WIDTH-1:0]        dt_reg;
    logic [SQ_W-1:0]              prod_reg;
    logic [SW-1:0]                acc_reg;
    logic [SW-1:0]                s_reg;
    logic [RW-1:0]                root_reg;
    logic [RW:0]                  rem_s_reg;
    logic [NUM_W-1:0]             num_reg;
    logic [TIME_WIDTH-1:0]        rem_d_reg;
    logic [tss_pkg::SPEED_W-1:0]  speed_reg;

    logic [POS_WIDTH-1:0]         mul_op;
    logic [RW+2:0]                sqrt_a;
    logic [TIME_WIDTH:0]          div_a;
    logic [W_SUB-1:0]             sub_a;
    logic [W_SUB-1:0]             sub_b;
    logic [W_SUB:0]               sub_diff;
    logic                         sub_ge;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    mul_op = dx_reg;
            2'd1:    mul_op = dy_reg;
            default: mul_op = dz_reg;
        endcase
    end

    assign sqrt_a = {rem_s_reg, s_reg[SW-1 -: 2]};
    assign div_a  = {rem_d_reg, num_reg[tss_pkg::SPEED_W-1]};

    // The shared subtract-and-compare unit.
    always_comb
    begin
        case (state_reg)
            C_SQRT:
            begin
                sub_a = W_SUB'(sqrt_a);
                sub_b = W_SUB'({root_reg, 2'b01});
            end
            C_CHK:
            begin
                sub_a = W_SUB'(num_reg[NUM_W-1 -: HI_W]);
                sub_b = W_SUB'(dt_reg);
            end
            C_DIV:
            begin
                sub_a = W_SUB'(div_a);
                sub_b = W_SUB'(dt_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = ~sub_diff[W_SUB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= C_SQ;
                    end
                end
                C_SQ:
                begin
                    if (cnt_reg == CNT_W'(2))
                    begin
                        state_reg <= C_ACC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                C_ACC:
                begin
                    cnt_reg   <= CNT_W'(RW - 1);
                    state_reg <= C_SQRT;
                end
                C_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= C_SCALE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                C_SCALE:
                begin
                    state_reg <= C_CHK;
                end
                C_CHK:
                begin
                    // A high part at or above the interval means the quotient
                    // does not fit in 32 bits.
                    if (sub_ge)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        cnt_reg   <= CNT_W'(tss_pkg::SPEED_W - 1);
                        state_reg <= C_DIV;
                    end
                end
                C_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    dx_reg   <= dist_x;
                    dy_reg   <= dist_y;
                    dz_reg   <= dist_z;
                    dt_reg   <= interval;
                    prod_reg <= '0;
                    acc_reg  <= '0;
                end
            end
            C_SQ:
            begin
                prod_reg <= SQ_W'(mul_op) * SQ_W'(mul_op);
                acc_reg  <= acc_reg + SW'(prod_reg);
            end
            C_ACC:
            begin
                s_reg     <= acc_reg + SW'(prod_reg);
                root_reg  <= '0;
                rem_s_reg <= '0;
            end
            C_SQRT:
            begin
                rem_s_reg <= sub_ge ? sub_diff[RW:0] : sqrt_a[RW:0];
                root_reg  <= {root_reg[RW-2:0], sub_ge};
                s_reg     <= s_reg << 2;
            end
            C_SCALE:
            begin
                num_reg <= NUM_W'(root_reg) * NUM_W'(tss_pkg::US_PER_S);
            end
            C_CHK:
            begin
                if (sub_ge)
                begin
                    speed_reg <= tss_pkg::SPEED_MAX;
                end
                rem_d_reg <= TIME_WIDTH'(num_reg[NUM_W-1 -: HI_W]);
            end
            C_DIV:
            begin
                rem_d_reg <= sub_ge ? sub_diff[TIME_WIDTH-1:0] : div_a[TIME_WIDTH-1:0];
                speed_reg <= {speed_reg[tss_pkg::SPEED_W-2:0], sub_ge};
                num_reg   <= num_reg << 1;
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign speed = speed_reg;

endmodule

`default_nettype wire

>>> rtl/tracked_speed_sampler.sv
`timescale 1ns / 1ps
`default_nettype none

// A speed over a nonzero interval goes through the core: it squares and sums the distances,
// takes the bit-serial square root (POS_WIDTH + 1 steps), scales it, checks for saturation and,
// unless the quotient saturates, runs the bit-serial division (32 steps). A sample that emits
// a speed holds the input until the speed enters the output register, and a full output
// register adds its wait; any other word leaves the input ready. Reset (rst_n, asynchronous,
// active low) clears the history, re-arms the emit timer 1 s before zero, id 0, period 10000.
module tracked_speed_sampler #(
    parameter int POS_WIDTH  = tss_pkg::POS_WIDTH_DEF,
    parameter int TIME_WIDTH = tss_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tss_sample_if.sink                             samples,
    tss_speed_if.source                            speeds,
    input  wire logic                              cfg_we,
    input  wire logic [tss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // The emit test runs in a signed width that holds any time and period.
    localparam int EW = ((TIME_WIDTH > tss_pkg::PERIOD_W) ? TIME_WIDTH : tss_pkg::PERIOD_W) + 2;
    localparam logic signed [TIME_WIDTH:0] EMIT_INIT = -((TIME_WIDTH + 1)'(tss_pkg::EMIT_RESET_US));

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CALC  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    state_t                           state_reg;
    logic [tss_pkg::ID_W-1:0]         tracked_id_reg;
    logic [tss_pkg::PERIOD_W-1:0]     period_reg;
    logic signed [POS_WIDTH-1:0]      prev_x_reg;
    logic signed [POS_WIDTH-1:0]      prev_y_reg;
    logic signed [POS_WIDTH-1:0]      prev_z_reg;
    logic [TIME_WIDTH-1:0]            prev_time_reg;
    logic [1:0]                       sample_count_reg;
    logic signed [TIME_WIDTH:0]       last_emit_reg;

    // Pending result, waiting either for the core or for the output slot.
    logic [tss_pkg::SPEED_W-1:0]      res_speed_reg;
    logic [TIME_WIDTH-1:0]            res_time_reg;
    logic                             res_flag_reg;

    // Output register, which frees the input side while a word waits downstream.
    logic                             out_valid_reg;
    logic [tss_pkg::SPEED_W-1:0]      out_speed_reg;
    logic [TIME_WIDTH-1:0]            out_time_reg;
    logic                             out_flag_reg;

    logic                             accept;
    logic                             is_clear;
    logic                             is_match;
    logic                             history_full;
    logic [POS_WIDTH-1:0]             dist_x;
    logic [POS_WIDTH-1:0]             dist_y;
    logic [POS_WIDTH-1:0]             dist_z;
    logic [TIME_WIDTH-1:0]            interval;
    logic signed [EW-1:0]             emit_lhs;
    logic signed [EW-1:0]             emit_rhs;
    logic                             emit_due;
    logic                             emit;
    logic                             core_start;
    logic                             core_done;
    logic [tss_pkg::SPEED_W-1:0]      core_speed;
    logic                             out_free;

    // Magnitude of the difference of two signed positions.
    function automatic logic [POS_WIDTH-1:0] pos_dist(
        input logic signed [POS_WIDTH-1:0] a,
        input logic signed [POS_WIDTH-1:0] b
    );
        logic [POS_WIDTH:0] d;
        d = {a[POS_WIDTH-1], a} - {b[POS_WIDTH-1], b};
        return d[POS_WIDTH] ? POS_WIDTH'(-d) : d[POS_WIDTH-1:0];
    endfunction

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign is_clear      = (samples.kind == tss_pkg::KIND_CLEAR);
    assign is_match      = !is_clear && (samples.object_id == tracked_id_reg);
    assign history_full  = (sample_count_reg == 2'd2);

    assign dist_x   = pos_dist(samples.pos_x, prev_x_reg);
    assign dist_y   = pos_dist(samples.pos_y, prev_y_reg);
    assign dist_z   = pos_dist(samples.pos_z, prev_z_reg);
    assign interval = (samples.sample_time >= prev_time_reg)
                    ? samples.sample_time - prev_time_reg
                    : prev_time_reg - samples.sample_time;

    // A speed is due when the new time exceeds the last emit time by more than the period.
    assign emit_lhs = $signed(EW'(samples.sample_time)) - $signed(EW'(period_reg));
    assign emit_rhs = EW'(last_emit_reg);
    assign emit_due = emit_lhs > emit_rhs;
    assign emit     = accept && is_match && history_full && emit_due;

    assign core_start = emit && (interval != '0);
    assign out_free   = !out_valid_reg || speeds.ready;

    tss_core #(
        .POS_WIDTH  (POS_WIDTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (core_start),
        .dist_x   (dist_x),
        .dist_y   (dist_y),
        .dist_z   (dist_z),
        .interval (interval),
        .done     (core_done),
        .speed    (core_speed)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracked_id_reg <= tss_pkg::TRACKED_ID_RESET;
            period_reg     <= tss_pkg::OUTPUT_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tss_pkg::REG_TRACKED_ID:    tracked_id_reg <= cfg_data[tss_pkg::ID_W-1:0];
                tss_pkg::REG_OUTPUT_PERIOD: period_reg     <= cfg_data[tss_pkg::PERIOD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // History and emit timer. A clear word and reset give the same state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_z_reg       <= '0;
            prev_time_reg    <= '0;
            sample_count_reg <= '0;
            last_emit_reg    <= EMIT_INIT;
        end
        else if (accept)
        begin
            if (is_clear)
            begin
                prev_x_reg       <= '0;
                prev_y_reg       <= '0;
                prev_z_reg       <= '0;
                prev_time_reg    <= '0;
                sample_count_reg <= '0;
                last_emit_reg    <= EMIT_INIT;
            end
            else if (is_match)
            begin
                // Suppressed speeds still move the history forward.
                prev_x_reg    <= samples.pos_x;
                prev_y_reg    <= samples.pos_y;
                prev_z_reg    <= samples.pos_z;
                prev_time_reg <= samples.sample_time;
                if (!history_full)
                begin
                    sample_count_reg <= sample_count_reg + 2'd1;
                end
                if (emit)
                begin
                    last_emit_reg <= $signed({1'b0, samples.sample_time});
                end
            end
        end
    end

    // Sequencer: wait for the core when there is arithmetic to do, then hand the
    // result to the output register as soon as it is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new word may enter the output register in the cycle the old one leaves.
            if (state_reg == ST_WRITE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (speeds.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (emit)
                    begin
                        state_reg <= core_start ? ST_CALC : ST_WRITE;
                    end
                end
                ST_CALC:
                begin
                    if (core_done)
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_time_reg  <= samples.sample_time;
            res_flag_reg  <= (interval == '0);
            res_speed_reg <= tss_pkg::SPEED_MAX;
        end
        else if (state_reg == ST_CALC && core_done)
        begin
            res_speed_reg <= core_speed;
        end
        if (state_reg == ST_WRITE && out_free)
        begin
            out_speed_reg <= res_speed_reg;
            out_time_reg  <= res_time_reg;
            out_flag_reg  <= res_flag_reg;
        end
    end

    assign speeds.valid         = out_valid_reg;
    assign speeds.speed         = out_speed_reg;
    assign speeds.speed_time    = out_time_reg;
    assign speeds.zero_interval = out_flag_reg;

    // The core reports a result only while the sequencer waits for one.
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        core_done |-> state_reg == ST_CALC)
        else $error("core finished outside the calculation state");

    // A waiting output word is never overwritten by the next result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE && out_valid_reg && !speeds.ready) |=> state_reg == ST_WRITE)
        else $error("result written over a word still waiting downstream");

    // A zero interval always carries the saturated speed.
    a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_flag_reg) |-> out_speed_reg == tss_pkg::SPEED_MAX)
        else $error("zero interval word without saturated speed");

    // The sample count saturates at two.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> sample_count_reg != 2'd3)
        else $error("sample count ran past two");

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for tracked_speed_sampler.
//
// Position and clear words are fed through the sample channel from a queue
// that the stimulus process fills. A monitor watches both channels at the
// rising clock edge. For every sample word that is accepted, it runs a local
// model of the tracker and queues the speed word that must come out, if any.
// Every accepted speed word is compared field by field with the oldest
// expectation.
//
// The run has three idle profiles and several register settings. The
// settings include a zero period, the shortest nonzero period, the longest
// period, and both extreme object ids.
module tb;
    import tss_pkg::*;

    localparam int PW = POS_WIDTH_DEF;
    localparam int TW = TIME_WIDTH_DEF;

    // A speed over a nonzero interval takes the longest path through the core.
    // After the last expected word, the bench waits for SETTLE_CYCLES before a
    // register write, or before the end of the run.
    localparam int SETTLE_CYCLES = PW + 60;

    // The run fails if no word moves on either channel for this many cycles.
    localparam int STALL_LIMIT = 4000;

    localparam logic signed [PW-1:0] ONE_M  = 32'sh0001_0000;
    localparam logic signed [PW-1:0] POS_HI = 32'sh7FFF_FFFF;
    localparam logic signed [PW-1:0] POS_LO = 32'sh8000_0000;
    localparam logic [TW-1:0]        TOP_TIME   = '1;
    localparam logic [PERIOD_W-1:0]  PERIOD_MAX = '1;
    localparam logic [ID_W-1:0]      HOT_ID     = 16'hFFFF;

    typedef struct {
        logic                 kind;
        logic [ID_W-1:0]      object_id;
        logic signed [PW-1:0] pos_x;
        logic signed [PW-1:0] pos_y;
        logic signed [PW-1:0] pos_z;
        logic [TW-1:0]        sample_time;
    } sample_word_t;

    typedef struct {
        logic [SPEED_W-1:0] speed;
        logic [TW-1:0]      speed_time;
        logic               zero_interval;
    } speed_word_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tss_sample_if #(.POS_WIDTH(PW), .TIME_WIDTH(TW)) sample_ch ();
    tss_speed_if  #(.TIME_WIDTH(TW))                 speed_ch ();

    tracked_speed_sampler #(
        .POS_WIDTH  (PW),
        .TIME_WIDTH (TW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch.sink),
        .speeds    (speed_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Words still to be offered to the block, and speeds still to come from it.
    sample_word_t sample_q[$];
    speed_word_t  speed_q[$];

    // Idle rates, in percent, of the sender and of the receiver.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    int unsigned words_sent;
    int unsigned words_taken;
    int unsigned error_count;
    int unsigned quiet_cycles;
    logic        sample_taken;

    // Local copy of the registers and of the tracking history.
    logic [ID_W-1:0]      watch_id;
    logic [PERIOD_W-1:0]  emit_period;
    logic signed [PW-1:0] hist_x;
    logic signed [PW-1:0] hist_y;
    logic signed [PW-1:0] hist_z;
    logic [TW-1:0]        hist_time;
    int unsigned          hist_len;
    longint               last_emit_us;

    sample_word_t next_word;
    sample_word_t seen_word;
    speed_word_t  seen_speed;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // A clear word, and also reset, empties the history. It also re-arms the
    // emit timer one second before time zero.
    task automatic clear_history();
        hist_x       = '0;
        hist_y       = '0;
        hist_z       = '0;
        hist_time    = '0;
        hist_len     = 0;
        last_emit_us = -longint'(EMIT_RESET_US);
    endtask

    // This is the floor of the square root of a sum of squares. The result
    // is built one bit at a time, from the top bit down.
    function automatic logic [63:0] floor_root(input logic [127:0] sum_sq);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= sum_sq)
                root = trial;
        end
        return root;
    endfunction

    // This models one accepted sample word. It advances the local history,
    // and it queues the speed word that the block must emit, if any.
    task automatic predict_speed(input sample_word_t w);
        longint         now_us;
        longint         dxl;
        longint         dyl;
        longint         dzl;
        logic [63:0]    ax;
        logic [63:0]    ay;
        logic [63:0]    az;
        logic [63:0]    span;
        logic [127:0]   quot;
        logic [TW-1:0]  dt;
        speed_word_t    res;
        if (w.kind == KIND_CLEAR)
        begin
            clear_history();
            return;
        end
        // A sample for some other object changes nothing.
        if (w.object_id != watch_id)
            return;
        now_us = longint'(w.sample_time);
        if (hist_len >= 2 && now_us - longint'(emit_period) > last_emit_us)
        begin
            // The time difference is taken as a magnitude, so that time going
            // backwards still yields a speed.
            dt = (w.sample_time >= hist_time) ? w.sample_time - hist_time
                                              : hist_time - w.sample_time;
            res.speed_time = w.sample_time;
            if (dt == '0)
            begin
                res.speed         = SPEED_MAX;
                res.zero_interval = 1'b1;
            end
            else
            begin
                dxl  = longint'(w.pos_x) - longint'(hist_x);
                dyl  = longint'(w.pos_y) - longint'(hist_y);
                dzl  = longint'(w.pos_z) - longint'(hist_z);
                ax   = (dxl < 0) ? -dxl : dxl;
                ay   = (dyl < 0) ? -dyl : dyl;
                az   = (dzl < 0) ? -dzl : dzl;
                span = floor_root({64'd0, ax} * {64'd0, ax}
                                  + {64'd0, ay} * {64'd0, ay}
                                  + {64'd0, az} * {64'd0, az});
                quot = ({64'd0, span} * 128'(US_PER_S)) / {88'd0, dt};
                res.speed         = (quot > {96'd0, SPEED_MAX}) ? SPEED_MAX
                                                                : quot[SPEED_W-1:0];
                res.zero_interval = 1'b0;
            end
            speed_q.insert(speed_q.size(), res);
            last_emit_us = now_us;
        end
        // A suppressed speed still moves the history on to this sample.
        hist_x    = w.pos_x;
        hist_y    = w.pos_y;
        hist_z    = w.pos_z;
        hist_time = w.sample_time;
        if (hist_len < 2)
            hist_len++;
    endtask

    task automatic check_speed(input speed_word_t got);
        speed_word_t want;
        if (speed_q.size() == 0)
        begin
            $error("unexpected speed word: speed %0h, speed_time %0h, zero_interval %0b",
                   got.speed, got.speed_time, got.zero_interval);
            error_count++;
            return;
        end
        want = speed_q[0];
        speed_q.delete(0);
        if (got.speed !== want.speed)
        begin
            $error("speed: expected %0h, got %0h", want.speed, got.speed);
            error_count++;
        end
        if (got.speed_time !== want.speed_time)
        begin
            $error("speed_time: expected %0h, got %0h", want.speed_time, got.speed_time);
            error_count++;
        end
        if (got.zero_interval !== want.zero_interval)
        begin
            $error("zero_interval: expected %0b, got %0b",
                   want.zero_interval, got.zero_interval);
            error_count++;
        end
    endtask

    task automatic push_word(input logic k, input logic [ID_W-1:0] id,
                             input logic signed [PW-1:0] x, input logic signed [PW-1:0] y,
                             input logic signed [PW-1:0] z, input logic [TW-1:0] t);
        sample_word_t w;
        w.kind        = k;
        w.object_id   = id;
        w.pos_x       = x;
        w.pos_y       = y;
        w.pos_z       = z;
        w.sample_time = t;
        sample_q.insert(sample_q.size(), w);
    endtask

    // This queues a random track of n counted words for the current id.
    // Most words move the object a little, forward in time. The rest are
    // clears, repeated times, backward steps, jumps, still positions, and
    // foreign samples. Foreign samples are not counted, since the block
    // ignores them. When near_top is set, the track starts close to the top
    // of the time range. There the longest period can still let a speed out
    // after a clear.
    task automatic queue_track(input int n, input bit near_top);
        sample_word_t         w;
        logic signed [PW-1:0] cx;
        logic signed [PW-1:0] cy;
        logic signed [PW-1:0] cz;
        logic [TW-1:0]        ct;
        int                   counted;
        int                   pick;
        int                   sh;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        ct = near_top ? TOP_TIME - $urandom_range(0, 3000000) : TW'($urandom_range(0, 2000000));
        counted = 0;
        while (counted < n)
        begin
            pick          = $urandom_range(99);
            w.kind        = KIND_SAMPLE;
            w.object_id   = watch_id;
            if (pick < 6)
            begin
                w.object_id = ID_W'($urandom);
                if (w.object_id == watch_id)
                    w.object_id[0] = ~w.object_id[0];
                w.pos_x       = $urandom;
                w.pos_y       = $urandom;
                w.pos_z       = $urandom;
                w.sample_time = TW'({$urandom, $urandom});
                sample_q.insert(sample_q.size(), w);
                continue;
            end
            counted++;
            if (pick < 10)
            begin
                // The payload of a clear word is junk on purpose.
                w.kind        = KIND_CLEAR;
                w.object_id   = ID_W'($urandom);
                w.pos_x       = $urandom;
                w.pos_y       = $urandom;
                w.pos_z       = $urandom;
                w.sample_time = TW'({$urandom, $urandom});
                sample_q.insert(sample_q.size(), w);
                cx = $urandom;
                cy = $urandom;
                cz = $urandom;
                ct = near_top ? TOP_TIME - $urandom_range(0, 3000000)
                              : TW'($urandom_range(0, 2000000));
                continue;
            end
            sh = $urandom_range(0, 20);
            if (pick < 14)
            begin
                cx = cx + ($signed($urandom) >>> (31 - sh));
            end
            else if (pick < 18)
            begin
                ct = ct - $urandom_range(1, 50000);
                cy = cy + ($signed($urandom) >>> (31 - sh));
            end
            else if (pick < 22)
            begin
                cx = $urandom;
                cy = $urandom;
                cz = $urandom;
                ct = ct + $urandom_range(1, 1000);
            end
            else if (pick < 25)
            begin
                ct = TW'({$urandom, $urandom});
            end
            else if (pick < 28)
            begin
                ct = ct + $urandom_range(1, 20000);
            end
            else
            begin
                cx = cx + ($signed($urandom) >>> (31 - sh));
                cy = cy + ($signed($urandom) >>> (31 - sh));
                cz = cz + ($signed($urandom) >>> (31 - sh));
                ct = ct + $urandom_range(1, 20000);
            end
            w.pos_x       = cx;
            w.pos_y       = cy;
            w.pos_z       = cz;
            w.sample_time = ct;
            sample_q.insert(sample_q.size(), w);
        end
    endtask

    // This returns once every queued word has been accepted and every
    // expected speed has arrived. It then lets the core finish any word that
    // yields no result.
    task automatic drain();
        while (sample_q.size() != 0 || words_taken != words_sent || speed_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Registers are written only while the block is idle. The local copy
    // follows each write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_TRACKED_ID)
            watch_id = val[ID_W-1:0];
        else
            emit_period = val;
    endtask

    // Sender: the driver changes the channel at the falling edge. It offers a
    // new word only when the channel is empty, or when the previous word was
    // taken at the last rising edge. It may also hold off, with a chance set
    // by the current idle rate.
    always @(negedge clk)
    begin
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || sample_taken)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_word = sample_q[0];
                sample_q.delete(0);
                sample_ch.valid       <= 1'b1;
                sample_ch.kind        <= next_word.kind;
                sample_ch.object_id   <= next_word.object_id;
                sample_ch.pos_x       <= next_word.pos_x;
                sample_ch.pos_y       <= next_word.pos_y;
                sample_ch.pos_z       <= next_word.pos_z;
                sample_ch.sample_time <= next_word.sample_time;
                words_sent++;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // Receiver: ready is redrawn at every falling edge.
    always @(negedge clk)
    begin
        speed_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: both channels are sampled at the rising edge. Accepted sample
    // words feed the model, and accepted speed words are checked. The
    // watchdog ends the run when traffic stops for too long.
    always @(posedge clk)
    begin
        sample_taken <= rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                seen_word.kind        = sample_ch.kind;
                seen_word.object_id   = sample_ch.object_id;
                seen_word.pos_x       = sample_ch.pos_x;
                seen_word.pos_y       = sample_ch.pos_y;
                seen_word.pos_z       = sample_ch.pos_z;
                seen_word.sample_time = sample_ch.sample_time;
                predict_speed(seen_word);
                words_taken++;
            end
            if (speed_ch.valid && speed_ch.ready)
            begin
                seen_speed.speed         = speed_ch.speed;
                seen_speed.speed_time    = speed_ch.speed_time;
                seen_speed.zero_interval = speed_ch.zero_interval;
                check_speed(seen_speed);
            end
            if ((sample_ch.valid && sample_ch.ready) || (speed_ch.valid && speed_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.kind        = KIND_SAMPLE;
        sample_ch.object_id   = '0;
        sample_ch.pos_x       = '0;
        sample_ch.pos_y       = '0;
        sample_ch.pos_z       = '0;
        sample_ch.sample_time = '0;
        speed_ch.ready        = 1'b0;
        sample_taken          = 1'b0;
        words_sent            = 0;
        words_taken           = 0;
        error_count           = 0;
        quiet_cycles          = 0;
        send_idle_pct         = 29;
        recv_idle_pct         = 79;
        watch_id              = TRACKED_ID_RESET;
        emit_period           = OUTPUT_PERIOD_RESET;
        clear_history();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The first profile uses the all-ones id and a zero period. Any later
        // time then lets a speed out, and an equal or earlier time holds it
        // back.
        write_reg(REG_TRACKED_ID, CFG_DATA_W'(HOT_ID));
        write_reg(REG_OUTPUT_PERIOD, '0);

        // The first two samples are only stored. A foreign sample with
        // extreme fields is ignored in between.
        push_word(KIND_SAMPLE, HOT_ID, '0, '0, '0, '0);
        push_word(KIND_SAMPLE, 16'h0000, POS_HI, POS_LO, POS_HI, TOP_TIME);
        push_word(KIND_SAMPLE, HOT_ID, ONE_M, '0, '0, 40'd1000);
        push_word(KIND_SAMPLE, HOT_ID, ONE_M, 2 * ONE_M, -2 * ONE_M, 40'd2000);
        // Time goes backwards. The speed is suppressed, and the history moves on.
        push_word(KIND_SAMPLE, HOT_ID, 3 * ONE_M, 2 * ONE_M, -2 * ONE_M, 40'd1500);
        push_word(KIND_SAMPLE, HOT_ID, 3 * ONE_M, -ONE_M, '0, 40'd3000);
        // Jumps across the whole position range saturate the speed.
        push_word(KIND_SAMPLE, HOT_ID, POS_HI, POS_LO, POS_HI, 40'd3001);
        push_word(KIND_SAMPLE, HOT_ID, POS_LO, POS_HI, POS_LO, 40'd3002);
        // Standing still gives a speed of zero.
        push_word(KIND_SAMPLE, HOT_ID, POS_LO, POS_HI, POS_LO, 40'd9000);
        // A clear word ignores its payload.
        push_word(KIND_CLEAR, 16'h1234, POS_HI, POS_LO, -1, TOP_TIME);
        // Three samples at one time give a zero interval on the third one.
        push_word(KIND_SAMPLE, HOT_ID, '0, '0, '0, 40'd7000);
        push_word(KIND_SAMPLE, HOT_ID, ONE_M, '0, '0, 40'd7000);
        push_word(KIND_SAMPLE, HOT_ID, 2 * ONE_M, '0, '0, 40'd7000);
        push_word(KIND_SAMPLE, HOT_ID, 2 * ONE_M, '0, '0, 40'd7000);
        push_word(KIND_SAMPLE, HOT_ID, 2 * ONE_M + 1, '0, '0, 40'd7001);
        push_word(KIND_CLEAR, '0, '0, '0, '0, '0);
        // These samples sit at the top of the time range, then wrap down to
        // zero and come back up.
        push_word(KIND_SAMPLE, HOT_ID, -1, -1, -1, TOP_TIME);
        push_word(KIND_SAMPLE, HOT_ID, '0, '0, '0, TOP_TIME - 5);
        push_word(KIND_SAMPLE, HOT_ID, ONE_M, ONE_M, ONE_M, '0);
        push_word(KIND_SAMPLE, HOT_ID, '0, '0, '0, TOP_TIME);

        queue_track(300, 1'b0);
        drain();

        // In the second profile the sender mostly waits and the receiver
        // rarely does. The longest period is tried first, near the top of
        // time. Then a random id gets the shortest nonzero period.
        send_idle_pct = 79;
        recv_idle_pct = 29;
        write_reg(REG_TRACKED_ID, '0);
        write_reg(REG_OUTPUT_PERIOD, CFG_DATA_W'(PERIOD_MAX));
        queue_track(40, 1'b1);
        drain();
        write_reg(REG_TRACKED_ID, CFG_DATA_W'($urandom_range(1, 65534)));
        write_reg(REG_OUTPUT_PERIOD, 40'd1);
        queue_track(300, 1'b0);
        drain();

        // In the last profile nobody idles, so words go back to back. A
        // middling period drops some speeds.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_TRACKED_ID, 40'h0A5C3);
        write_reg(REG_OUTPUT_PERIOD, 40'd1000);
        queue_track(300, 1'b0);
        drain();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tss_pkg.sv
rtl/tss_sample_if.sv
rtl/tss_speed_if.sv
rtl/tss_core.sv
rtl/tracked_speed_sampler.sv
test/tb.sv
